/* hw/rtl/stunmp_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// STUN message parser package
// Result codes, error codes, framing constants and the result record.
// ----------------------------------------------------------------------------
package stunmp_pkg;

  localparam logic [2:0] KIND_HEADER = 3'd0;
  localparam logic [2:0] KIND_ATTR_HDR = 3'd1;
  localparam logic [2:0] KIND_ATTR_VAL = 3'd2;
  localparam logic [2:0] KIND_ACCEPT = 3'd3;
  localparam logic [2:0] KIND_REJECT = 3'd4;

  localparam logic [2:0] ERR_NONE = 3'd0;
  localparam logic [2:0] ERR_SIZE = 3'd1;
  localparam logic [2:0] ERR_TYPE_BITS = 3'd2;
  localparam logic [2:0] ERR_COOKIE = 3'd3;
  localparam logic [2:0] ERR_LENGTH = 3'd4;
  localparam logic [2:0] ERR_OVERRUN = 3'd5;

  localparam logic [31:0] STUN_COOKIE = 32'h2112_A442;
  localparam logic [7:0] TOP_BITS = 8'hC0;
  localparam logic [16:0] HEADER_SIZE = 17'd20;
  localparam logic [16:0] COUNT_MAX = 17'h1_FFFF;

  typedef struct packed {
    logic [2:0] kind;
    logic [11:0] method;
    logic [1:0] msg_class;
    logic [31:0] txid_high;
    logic [63:0] txid_low;
    logic [15:0] attr_type;
    logic [15:0] attr_length;
    logic [7:0] value_byte;
    logic [15:0] value_index;
    logic [2:0] error_kind;
    logic last;
  } result_t;

  // Attribute value length rounded up to a whole 4-byte word.
  function automatic logic [16:0] padded_len(input logic [15:0] len);
    logic [16:0] sum;
    sum = {1'b0, len} + 17'd3;
    return {sum[16:2], 2'b00};
  endfunction

endpackage

/* hw/rtl/stun_message_parser.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// STUN message parser
// Parses a STUN packet one byte per transfer: header checks, method and class
// split, transaction ID, attribute walk, and a final accept or reject result.
// ----------------------------------------------------------------------------
//  Channel   Direction  Handshake            Payload
//  in_       input      in_valid/in_ready    data_byte, last_byte
//  out_      output     out_valid/out_ready  one result record per transfer
//
//  One byte is taken per cycle while in_ready is high; its results are computed
//  in the same cycle and written into a four-entry result queue that drives
//  out_valid. A byte can give two results (for example a header or attribute
//  result followed by the packet verdict); the queue drains one per cycle while
//  out_ready is high; in_ready drops only while fewer than two entries are free.
//  Reset is synchronous on rst_n and empties the queue and parser state.

module stun_message_parser
  import stunmp_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_data_byte,
  input  logic        in_last_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  out_kind,
  output logic [11:0] out_method,
  output logic [1:0]  out_msg_class,
  output logic [31:0] out_txid_high,
  output logic [63:0] out_txid_low,
  output logic [15:0] out_attr_type,
  output logic [15:0] out_attr_length,
  output logic [7:0]  out_value_byte,
  output logic [15:0] out_value_index,
  output logic [2:0]  out_error_kind,
  output logic        out_last
);

  typedef enum logic [1:0] {
    PH_HEADER,
    PH_ATTR,
    PH_DONE,
    PH_FAIL
  } phase_t;

  phase_t phase_r, phase_nxt;
  logic [16:0] byte_cnt_r, byte_cnt_nxt;
  logic [15:0] type_word_r, type_word_nxt;
  logic [15:0] len_word_r, len_word_nxt;
  logic [31:0] cookie_r, cookie_nxt;
  logic [31:0] txid_hi_r, txid_hi_nxt;
  logic [63:0] txid_lo_r, txid_lo_nxt;
  logic [15:0] attr_type_r, attr_type_nxt;
  logic [15:0] attr_len_r, attr_len_nxt;
  logic [17:0] attr_off_r, attr_off_nxt;
  logic [2:0] first_err_r, first_err_nxt;

  result_t fifo_r [4];
  logic [1:0] wr_ptr_r, rd_ptr_r;
  logic [2:0] count_r;

  logic main_vld;
  result_t main_res, fin_res;
  logic [16:0] body;
  logic [16:0] pad_cur, pad_new;
  logic [15:0] len_new;
  logic [17:0] end_sum, body_p1, idx;
  logic [17:0] size;
  logic [2:0] fin_err;
  logic in_fire, out_fire;
  logic [1:0] n_push;

  assign in_fire = in_valid && in_ready;
  assign out_fire = out_valid && out_ready;
  assign in_ready = (count_r < 3'd3);
  assign out_valid = (count_r != 3'd0);
  assign n_push = in_fire ? (2'(main_vld) + 2'(in_last_byte)) : 2'd0;

  assign body = byte_cnt_r - HEADER_SIZE;
  assign body_p1 = {1'b0, body} + 18'd1;
  assign pad_cur = padded_len(attr_len_r);
  assign len_new = {attr_len_r[7:0], in_data_byte};
  assign pad_new = padded_len(len_new);
  assign end_sum = body_p1 + {1'b0, pad_new};
  assign idx = attr_off_r - 18'd4;

  always_comb begin
    phase_nxt = phase_r;
    type_word_nxt = type_word_r;
    len_word_nxt = len_word_r;
    cookie_nxt = cookie_r;
    txid_hi_nxt = txid_hi_r;
    txid_lo_nxt = txid_lo_r;
    attr_type_nxt = attr_type_r;
    attr_len_nxt = attr_len_r;
    attr_off_nxt = attr_off_r;
    first_err_nxt = first_err_r;
    main_vld = 1'b0;
    main_res = '0;
    fin_res = '0;
    size = '0;
    fin_err = ERR_NONE;

    if (byte_cnt_r < HEADER_SIZE) begin
      if (byte_cnt_r < 17'd2) begin
        type_word_nxt = {type_word_r[7:0], in_data_byte};
        if (byte_cnt_r == 17'd0 && (in_data_byte & TOP_BITS) != 8'd0 &&
            first_err_r == ERR_NONE) begin
          first_err_nxt = ERR_TYPE_BITS;
        end
      end else if (byte_cnt_r < 17'd4) begin
        len_word_nxt = {len_word_r[7:0], in_data_byte};
      end else if (byte_cnt_r < 17'd8) begin
        cookie_nxt = {cookie_r[23:0], in_data_byte};
        if (byte_cnt_r == 17'd7 && cookie_nxt != STUN_COOKIE &&
            first_err_r == ERR_NONE) begin
          first_err_nxt = ERR_COOKIE;
        end
      end else if (byte_cnt_r < 17'd12) begin
        txid_hi_nxt = {txid_hi_r[23:0], in_data_byte};
      end else begin
        txid_lo_nxt = {txid_lo_r[55:0], in_data_byte};
      end
      if (byte_cnt_r == HEADER_SIZE - 17'd1) begin
        attr_off_nxt = '0;
        if (first_err_nxt != ERR_NONE) begin
          phase_nxt = PH_FAIL;
        end else begin
          main_vld = 1'b1;
          main_res.kind = KIND_HEADER;
          main_res.method = {type_word_r[13:9], type_word_r[7:5], type_word_r[3:0]};
          main_res.msg_class = {type_word_r[8], type_word_r[4]};
          main_res.txid_high = txid_hi_r;
          main_res.txid_low = txid_lo_nxt;
          phase_nxt = (len_word_r == 16'd0) ? PH_DONE : PH_ATTR;
        end
      end
    end else if (phase_r == PH_ATTR) begin
      if (attr_off_r < 18'd4) begin
        if (attr_off_r < 18'd2) begin
          attr_type_nxt = {attr_type_r[7:0], in_data_byte};
        end else begin
          attr_len_nxt = len_new;
        end
        if (attr_off_r == 18'd3) begin
          if (end_sum > {2'b00, len_word_r}) begin
            if (first_err_r == ERR_NONE) begin
              first_err_nxt = ERR_OVERRUN;
            end
            phase_nxt = PH_FAIL;
          end else begin
            main_vld = 1'b1;
            main_res.kind = KIND_ATTR_HDR;
            main_res.attr_type = attr_type_r;
            main_res.attr_length = len_new;
            if (pad_new == 17'd0) begin
              attr_off_nxt = '0;
              if (body_p1 == {2'b00, len_word_r}) begin
                phase_nxt = PH_DONE;
              end
            end else begin
              attr_off_nxt = 18'd4;
            end
          end
        end else begin
          attr_off_nxt = attr_off_r + 18'd1;
        end
      end else begin
        if (idx < {2'b00, attr_len_r}) begin
          main_vld = 1'b1;
          main_res.kind = KIND_ATTR_VAL;
          main_res.attr_type = attr_type_r;
          main_res.attr_length = attr_len_r;
          main_res.value_byte = in_data_byte;
          main_res.value_index = idx[15:0];
        end
        if (attr_off_r + 18'd1 >= 18'd4 + {1'b0, pad_cur}) begin
          attr_off_nxt = '0;
          if (body_p1 == {2'b00, len_word_r}) begin
            phase_nxt = PH_DONE;
          end
        end else begin
          attr_off_nxt = attr_off_r + 18'd1;
        end
      end
    end

    byte_cnt_nxt = (byte_cnt_r != COUNT_MAX) ? byte_cnt_r + 17'd1 : byte_cnt_r;

    size = {1'b0, byte_cnt_r} + 18'd1;
    fin_err = first_err_nxt;
    if (fin_err == ERR_NONE) begin
      if (size < 18'd20 || size[1:0] != 2'b00) begin
        fin_err = ERR_SIZE;
      end else if (size != {2'b00, len_word_nxt} + 18'd20) begin
        fin_err = ERR_LENGTH;
      end
    end
    fin_res.kind = (fin_err == ERR_NONE) ? KIND_ACCEPT : KIND_REJECT;
    fin_res.error_kind = fin_err;
    fin_res.last = 1'b1;
    main_res.last = !in_last_byte;
  end

  always_ff @(posedge clk) begin
    if (!rst_n || (in_fire && in_last_byte)) begin
      phase_r <= PH_HEADER;
      byte_cnt_r <= '0;
      type_word_r <= '0;
      len_word_r <= '0;
      cookie_r <= '0;
      txid_hi_r <= '0;
      txid_lo_r <= '0;
      attr_type_r <= '0;
      attr_len_r <= '0;
      attr_off_r <= '0;
      first_err_r <= ERR_NONE;
    end else if (in_fire) begin
      phase_r <= phase_nxt;
      byte_cnt_r <= byte_cnt_nxt;
      type_word_r <= type_word_nxt;
      len_word_r <= len_word_nxt;
      cookie_r <= cookie_nxt;
      txid_hi_r <= txid_hi_nxt;
      txid_lo_r <= txid_lo_nxt;
      attr_type_r <= attr_type_nxt;
      attr_len_r <= attr_len_nxt;
      attr_off_r <= attr_off_nxt;
      first_err_r <= first_err_nxt;
    end

    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r <= '0;
    end else begin
      if (in_fire) begin
        if (main_vld) begin
          fifo_r[wr_ptr_r] <= main_res;
          if (in_last_byte) begin
            fifo_r[wr_ptr_r + 2'd1] <= fin_res;
          end
        end else if (in_last_byte) begin
          fifo_r[wr_ptr_r] <= fin_res;
        end
      end
      wr_ptr_r <= wr_ptr_r + n_push;
      rd_ptr_r <= rd_ptr_r + 2'(out_fire);
      count_r <= count_r + 3'(n_push) - 3'(out_fire);
    end
  end

  assign out_kind = fifo_r[rd_ptr_r].kind;
  assign out_method = fifo_r[rd_ptr_r].method;
  assign out_msg_class = fifo_r[rd_ptr_r].msg_class;
  assign out_txid_high = fifo_r[rd_ptr_r].txid_high;
  assign out_txid_low = fifo_r[rd_ptr_r].txid_low;
  assign out_attr_type = fifo_r[rd_ptr_r].attr_type;
  assign out_attr_length = fifo_r[rd_ptr_r].attr_length;
  assign out_value_byte = fifo_r[rd_ptr_r].value_byte;
  assign out_value_index = fifo_r[rd_ptr_r].value_index;
  assign out_error_kind = fifo_r[rd_ptr_r].error_kind;
  assign out_last = fifo_r[rd_ptr_r].last;

endmodule

/* hw/rtl/stunmp_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// STUN message parser port checker
// Checks result transfers seen on the parser's ports.
// ----------------------------------------------------------------------------
module stunmp_checker
  import stunmp_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [2:0]  out_kind,
  input logic [15:0] out_attr_length,
  input logic [15:0] out_value_index,
  input logic [2:0]  out_error_kind,
  input logic        out_last
);

  // A stalled result must hold.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_kind) && $stable(out_last))
    else $error("result changed while stalled");

  // The packet verdict is always the last result of its byte.
  a_verdict_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_kind == KIND_ACCEPT || out_kind == KIND_REJECT) |-> out_last)
    else $error("verdict without last");

  // Only a reject carries an error, and a reject always carries one.
  a_err_match: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((out_kind == KIND_REJECT) == (out_error_kind != ERR_NONE)))
    else $error("error code does not match result kind");

  // Value byte positions stay inside the attribute length.
  a_value_index: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == KIND_ATTR_VAL |-> out_value_index < out_attr_length)
    else $error("value index beyond attribute length");

endmodule

bind stun_message_parser stunmp_checker u_stunmp_checker (
  .clk(clk),
  .rst_n(rst_n),
  .out_valid(out_valid),
  .out_ready(out_ready),
  .out_kind(out_kind),
  .out_attr_length(out_attr_length),
  .out_value_index(out_value_index),
  .out_error_kind(out_error_kind),
  .out_last(out_last)
);
